>>> rtl/assert_macros.svh
// Assertion macros shared by the sorted timer queue RTL.
// Compiled to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define STQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define STQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define STQ_ASSERT(lbl, clk, rstn, prop)
`define STQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/stq_pkg.sv
// Types and constants for the sorted timer queue.
// No dependencies; used by stq_cell and sorted_timer_queue_top.
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int TIME_W   = 32;
    localparam int ID_FIELD = 8;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_RESCHED = 2'd1;
    localparam logic [1:0] ACT_DELETE  = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_EXPIRED  = 2'd3;

    typedef struct packed {
        logic remove;
        logic pop;
        logic place;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/stq_cell.sv
// One slot of the sorted timer chain: holds an id and an expiry time.
// Shifts toward the head on remove and pop, away from it on place. Uses stq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stq_cell #(
    parameter int ID_W = 8
) (
    input  wire                          aclk,
    input  stq_pkg::cell_cmd_t           cmd,
    input  wire                          occ,
    input  wire [ID_W-1:0]               key_id,
    input  wire [stq_pkg::TIME_W-1:0]    key_time,
    input  wire [ID_W-1:0]               prev_id,
    input  wire [stq_pkg::TIME_W-1:0]    prev_time,
    input  wire                          prev_le,
    input  wire [ID_W-1:0]               next_id,
    input  wire [stq_pkg::TIME_W-1:0]    next_time,
    input  wire                          match_in,
    output logic [ID_W-1:0]              id_q,
    output logic [stq_pkg::TIME_W-1:0]   time_q,
    output logic                         le_out,
    output logic                         match_out
);

    logic [ID_W-1:0]            id_reg, id_next;
    logic [stq_pkg::TIME_W-1:0] time_reg, time_next;

    assign id_q      = id_reg;
    assign time_q    = time_reg;
    assign le_out    = occ && (time_reg <= key_time);
    assign match_out = match_in || (occ && (id_reg == key_id));

    always_comb begin
        id_next   = id_reg;
        time_next = time_reg;
        if (cmd.pop || (cmd.remove && match_out)) begin
            id_next   = next_id;
            time_next = next_time;
        end else if (cmd.place && !le_out) begin
            if (prev_le) begin
                id_next   = key_id;
                time_next = key_time;
            end else begin
                id_next   = prev_id;
                time_next = prev_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_timer_queue_top.sv
// Sorted timer queue: a chain of DEPTH timer cells kept in expiry order, with its controller.
// Depends on stq_pkg, stq_cell and assert_macros.svh.
//
// Holds up to DEPTH timers sorted by expiry; equal expiries leave first-in first-out.
// One action is taken at a time. A delete or a failed action passes the find and emit
// states after its transfer, an insert or reschedule the find, place and emit states
// (find locates the id and closes the gap, place opens a slot and shifts the tail of the
// chain). A tick pops expired timers from the head, one per cycle while the result is
// taken, the chain moving by one cell per pop; a tick with nothing expired gives no
// result and frees the input again. A stalled result stalls the chain. There is no
// clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_timer_queue_top #(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // timer_id[7:0], expire_time[39:8], current_time[71:40]
    input  wire  [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // expired_id[7:0], expired_time[39:8]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    localparam int IdW  = (ID_WIDTH < stq_pkg::ID_FIELD) ? ID_WIDTH : stq_pkg::ID_FIELD;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam int TW   = stq_pkg::TIME_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_TICK  = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [1:0]      act_reg;
    logic [IdW-1:0]  id_reg;
    logic [TW-1:0]   exp_reg, now_reg;
    logic [1:0]      stat_reg, stat_next;

    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_stat_reg, m_stat_next;
    logic [IdW-1:0]  m_id_reg, m_id_next;
    logic [TW-1:0]   m_time_reg, m_time_next;
    logic            m_last_reg, m_last_next;

    logic [IdW-1:0]  cell_id   [DEPTH];
    logic [TW-1:0]   cell_time [DEPTH];
    logic            cell_le   [DEPTH];
    logic            cell_match[DEPTH];

    stq_pkg::cell_cmd_t cmd;
    logic in_xfer, out_free, out_load, found, full, head_exp, next_exp, pop_en;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign found    = cell_match[DEPTH-1];
    assign full     = (count_reg == CntW'(DEPTH));
    assign head_exp = (count_reg != '0) && (cell_time[0] <= now_reg);
    assign next_exp = (count_reg > CntW'(1)) && (cell_time[1] <= now_reg);
    assign pop_en   = (state_reg == S_TICK) && head_exp && out_free;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [IdW-1:0] p_id, n_id;
            logic [TW-1:0]  p_time, n_time;
            logic           p_le, m_in;
            if (i == 0) begin : g_head
                assign p_id   = id_reg;
                assign p_time = exp_reg;
                assign p_le   = 1'b1;
                assign m_in   = 1'b0;
            end else begin : g_body
                assign p_id   = cell_id[i-1];
                assign p_time = cell_time[i-1];
                assign p_le   = cell_le[i-1];
                assign m_in   = cell_match[i-1];
            end
            if (i == DEPTH - 1) begin : g_tail
                assign n_id   = cell_id[i];
                assign n_time = cell_time[i];
            end else begin : g_inner
                assign n_id   = cell_id[i+1];
                assign n_time = cell_time[i+1];
            end
            stq_cell #(.ID_W(IdW)) u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .occ       (count_reg > CntW'(i)),
                .key_id    (id_reg),
                .key_time  (exp_reg),
                .prev_id   (p_id),
                .prev_time (p_time),
                .prev_le   (p_le),
                .next_id   (n_id),
                .next_time (n_time),
                .match_in  (m_in),
                .id_q      (cell_id[i]),
                .time_q    (cell_time[i]),
                .le_out    (cell_le[i]),
                .match_out (cell_match[i])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        stat_next    = stat_reg;
        cmd          = '0;
        out_load     = 1'b0;
        m_stat_next  = m_stat_reg;
        m_id_next    = m_id_reg;
        m_time_next  = m_time_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = (s_tuser == stq_pkg::ACT_TICK) ? S_TICK : S_FIND;
                end
            end
            S_FIND: begin
                cmd.remove = found;
                if (found) begin
                    count_next = count_reg - CntW'(1);
                end
                stat_next = stq_pkg::STAT_OK;
                case (act_reg)
                    stq_pkg::ACT_INSERT: begin
                        if (found || !full) begin
                            state_next = S_PLACE;
                        end else begin
                            stat_next  = stq_pkg::STAT_FULL;
                            state_next = S_EMIT;
                        end
                    end
                    stq_pkg::ACT_RESCHED: begin
                        if (found) begin
                            state_next = S_PLACE;
                        end else begin
                            stat_next  = stq_pkg::STAT_NOTFOUND;
                            state_next = S_EMIT;
                        end
                    end
                    default: begin
                        if (!found) begin
                            stat_next = stq_pkg::STAT_NOTFOUND;
                        end
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                count_next = count_reg + CntW'(1);
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    m_stat_next = stat_reg;
                    m_id_next   = id_reg;
                    m_time_next = '0;
                    m_last_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TICK: begin
                if (!head_exp) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    cmd.pop     = 1'b1;
                    count_next  = count_reg - CntW'(1);
                    out_load    = 1'b1;
                    m_stat_next = stq_pkg::STAT_EXPIRED;
                    m_id_next   = cell_id[0];
                    m_time_next = cell_time[0];
                    m_last_next = !next_exp;
                    if (!next_exp) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        stat_reg   <= stat_next;
        m_stat_reg <= m_stat_next;
        m_id_reg   <= m_id_next;
        m_time_reg <= m_time_next;
        m_last_reg <= m_last_next;
        if (in_xfer) begin
            act_reg <= s_tuser;
            id_reg  <= s_tdata[IdW-1:0];
            exp_reg <= s_tdata[39:8];
            now_reg <= s_tdata[71:40];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_time_reg, stq_pkg::ID_FIELD'(m_id_reg)};

    `STQ_ASSERT(a_count_bound, aclk, aresetn, (count_reg <= CntW'(DEPTH)))
    `STQ_ASSERT_IMP(a_place_room, aclk, aresetn, (state_reg == S_PLACE), (!full))
    `STQ_ASSERT(a_pop_count, aclk, aresetn, (pop_en |=> (count_reg == $past(count_reg) - CntW'(1))))
    `STQ_ASSERT_IMP(a_pop_emits, aclk, aresetn, pop_en, (out_load && (m_stat_next == stq_pkg::STAT_EXPIRED)))

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_timer_queue_top: directed table, then random traffic.
// Depends on stq_pkg and the RTL; results are checked against a bench model or a table row.

module testbench;

    localparam int DEPTH          = 16;
    localparam int ID_WIDTH       = 8;
    localparam int RANDOM_ITEMS   = 385;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  tid;
        logic [31:0] ttime;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [1:0]    act;
        logic [7:0]    tid;
        logic [31:0]   exp_t;
        logic [31:0]   now_t;
        bit            typed;
        timer_result_t ref_res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // timer_id[7:0], expire_time[39:8], current_time[71:40]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // expired_id[7:0], expired_time[39:8]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        m_tlast;

    logic [7:0]    held_id[$];
    logic [31:0]   held_exp[$];
    timer_result_t step_out[$];
    timer_result_t pending_q[$];
    stim_row_t     directed_rows[$];

    bit            cur_typed;
    timer_result_t cur_ref;
    bit            idle_on;
    int            err_count;
    int            n_items;
    int            n_results;
    int            n_full;
    int            max_pop;
    int            stall_cycles;
    logic [31:0]   sim_now;

    sorted_timer_queue_top #(
        .DEPTH   (DEPTH),
        .ID_WIDTH(ID_WIDTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic void place_timer(logic [7:0] tid, logic [31:0] exp_t);
        int pos;
        pos = held_exp.size();
        for (int i = held_exp.size() - 1; i >= 0; i--) begin
            if (held_exp[i] > exp_t) begin
                pos = i;
            end
        end
        held_exp.insert(pos, exp_t);
        held_id.insert(pos, tid);
    endfunction

    function automatic void predict_timer_step(logic [1:0] act, logic [7:0] tid,
                                               logic [31:0] exp_t, logic [31:0] now_t);
        int         pos;
        logic [1:0] st;
        logic [7:0] id_m;
        step_out.delete();
        id_m = tid & 8'((1 << ID_WIDTH) - 1);
        if (act == stq_pkg::ACT_TICK) begin
            while (held_exp.size() > 0 && held_exp[0] <= now_t) begin
                step_out.push_back('{stq_pkg::STAT_EXPIRED, held_id[0], held_exp[0], 1'b0});
                held_id.delete(0);
                held_exp.delete(0);
            end
            if (step_out.size() > 0) begin
                step_out[step_out.size() - 1].last = 1'b1;
            end
        end else begin
            pos = -1;
            for (int i = 0; i < held_id.size(); i++) begin
                if (pos < 0 && held_id[i] == id_m) begin
                    pos = i;
                end
            end
            if (act == stq_pkg::ACT_INSERT && pos < 0 && held_id.size() >= DEPTH) begin
                st = stq_pkg::STAT_FULL;
            end else if (act != stq_pkg::ACT_INSERT && pos < 0) begin
                st = stq_pkg::STAT_NOTFOUND;
            end else begin
                if (pos >= 0) begin
                    held_id.delete(pos);
                    held_exp.delete(pos);
                end
                if (act != stq_pkg::ACT_DELETE) begin
                    place_timer(id_m, exp_t);
                end
                st = stq_pkg::STAT_OK;
            end
            step_out.push_back('{st, id_m, 32'd0, 1'b1});
        end
    endfunction

    always @(posedge aclk) begin
        timer_result_t got;
        timer_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast};
                n_results++;
                if (got.status == stq_pkg::STAT_FULL) begin
                    n_full++;
                end
                if (pending_q.size() == 0) begin
                    $error("result with nothing expected: status %0d id %0d time %0d last %0d",
                           got.status, got.tid, got.ttime, got.last);
                    err_count++;
                end else begin
                    want = pending_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_count++;
                    end
                    if (got.tid !== want.tid) begin
                        $error("expired_id: expected %0d, got %0d", want.tid, got.tid);
                        err_count++;
                    end
                    if (got.ttime !== want.ttime) begin
                        $error("expired_time: expected %0d, got %0d", want.ttime, got.ttime);
                        err_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_timer_step(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[71:40]);
                if (cur_typed) begin
                    pending_q.push_back(cur_ref);
                end else begin
                    foreach (step_out[i]) begin
                        pending_q.push_back(step_out[i]);
                    end
                end
                if (s_tuser == stq_pkg::ACT_TICK && step_out.size() > max_pop) begin
                    max_pop = step_out.size();
                end
                n_items++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("timeout: no transfer for %0d cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            gap = idle_on ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] tid,
                             input logic [31:0] exp_t, input logic [31:0] now_t,
                             input bit typed, input timer_result_t ref_res);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_typed = typed;
        cur_ref   = ref_res;
        s_tuser   = act;
        s_tdata   = {now_t, exp_t, tid};
        s_tvalid  = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic add_row(input logic [1:0] act, input logic [7:0] tid,
                           input logic [31:0] exp_t, input logic [31:0] now_t,
                           input bit typed, input logic [1:0] st,
                           input logic [31:0] ttime);
        stim_row_t row;
        row.act     = act;
        row.tid     = tid;
        row.exp_t   = exp_t;
        row.now_t   = now_t;
        row.typed   = typed;
        row.ref_res = '{st, tid, ttime, 1'b1};
        directed_rows.push_back(row);
    endtask

    task automatic run_random(input int n_rand);
        logic [1:0]  act;
        logic [7:0]  tid;
        logic [31:0] exp_t;
        logic [31:0] now_t;
        int          pick;
        bit          tick_heavy;
        for (int k = 0; k < n_rand; k++) begin
            if (k % 60 == 0) begin
                idle_on    = ($urandom_range(0, 3) != 0);
                tick_heavy = ($urandom_range(0, 1) != 0);
            end
            if (k == n_rand / 2) begin
                s_tvalid = 1'b0;
                while (pending_q.size() != 0) @(negedge aclk);
            end
            pick  = $urandom_range(0, 99);
            tid   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 21));
            exp_t = sim_now + $urandom_range(0, 40);
            now_t = $urandom;
            if (tick_heavy) begin
                act = (pick < 40) ? stq_pkg::ACT_INSERT : (pick < 60) ? stq_pkg::ACT_RESCHED :
                      (pick < 75) ? stq_pkg::ACT_DELETE : stq_pkg::ACT_TICK;
            end else begin
                act = (pick < 60) ? stq_pkg::ACT_INSERT : (pick < 78) ? stq_pkg::ACT_RESCHED :
                      (pick < 90) ? stq_pkg::ACT_DELETE : stq_pkg::ACT_TICK;
            end
            if (act == stq_pkg::ACT_TICK) begin
                if ($urandom_range(0, 19) == 0) begin
                    now_t = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom;
                end else begin
                    sim_now = sim_now + $urandom_range(0, 15);
                    now_t   = sim_now;
                end
            end else if ($urandom_range(0, 14) == 0) begin
                exp_t = $urandom;
            end
            send_item(act, tid, exp_t, now_t, 1'b0, '0);
        end
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = stq_pkg::ACT_INSERT;
        aresetn   = 1'b0;
        cur_typed = 1'b0;
        cur_ref   = '0;
        idle_on   = 1'b1;
        err_count = 0;
        n_items   = 0;
        n_results = 0;
        n_full    = 0;
        max_pop   = 0;
        sim_now   = $urandom_range(0, 1000);

        add_row(stq_pkg::ACT_TICK,    8'h00, 32'd0,         32'hFFFF_FFFF, 1'b0,
                stq_pkg::STAT_OK, 32'd0);
        add_row(stq_pkg::ACT_DELETE,  8'h00, 32'hFFFF_FFFF, 32'd0,         1'b1,
                stq_pkg::STAT_NOTFOUND, 32'd0);
        add_row(stq_pkg::ACT_RESCHED, 8'hFF, 32'd5,         32'hFFFF_FFFF, 1'b1,
                stq_pkg::STAT_NOTFOUND, 32'd0);
        add_row(stq_pkg::ACT_INSERT,  8'hFF, 32'hFFFF_FFFF, 32'd0,         1'b1,
                stq_pkg::STAT_OK, 32'd0);
        for (int i = 0; i < DEPTH - 1; i++) begin
            add_row(stq_pkg::ACT_INSERT, 8'(i), 32'd10 * (i % 4), $urandom, 1'b0,
                    stq_pkg::STAT_OK, 32'd0);
        end
        add_row(stq_pkg::ACT_INSERT,  8'h80, 32'd3,         32'd0,         1'b1,
                stq_pkg::STAT_FULL, 32'd0);
        add_row(stq_pkg::ACT_INSERT,  8'h07, 32'd0,         32'd0,         1'b1,
                stq_pkg::STAT_OK, 32'd0);
        add_row(stq_pkg::ACT_RESCHED, 8'h01, 32'd0,         32'd0,         1'b1,
                stq_pkg::STAT_OK, 32'd0);
        add_row(stq_pkg::ACT_DELETE,  8'h02, 32'd0,         32'd0,         1'b1,
                stq_pkg::STAT_OK, 32'd0);
        add_row(stq_pkg::ACT_TICK,    8'h00, 32'd0,         32'd0,         1'b0,
                stq_pkg::STAT_OK, 32'd0);
        add_row(stq_pkg::ACT_TICK,    8'h00, 32'd0,         32'hFFFF_FFFE, 1'b0,
                stq_pkg::STAT_OK, 32'd0);
        add_row(stq_pkg::ACT_TICK,    8'hFF, 32'd0,         32'hFFFF_FFFF, 1'b1,
                stq_pkg::STAT_EXPIRED, 32'hFFFF_FFFF);

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].act, directed_rows[i].tid, directed_rows[i].exp_t,
                      directed_rows[i].now_t, directed_rows[i].typed,
                      directed_rows[i].ref_res);
        end
        run_random(RANDOM_ITEMS);
        s_tvalid  = 1'b0;
        cur_typed = 1'b0;

        while (pending_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (pending_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_q.size());
            err_count++;
        end

        $display("Covered %0d input transfers (%0d directed) and %0d checked results,",
                 n_items, directed_rows.size(), n_results);
        $display("including %0d full rejects; the deepest tick popped %0d timers.",
                 n_full, max_pop);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
